// ===== rtl/bfd_pkg.sv =====
// Shared types, constants and codes for the box filter downscaler.
`timescale 1ns / 1ps

package bfd_pkg;

  localparam int MAX_SCALE_DEF = 16;
  localparam int PIX_W         = 8;
  localparam int COORD_W       = 16;
  localparam int PCNT_W        = 9;
  localparam int SCALE_W       = 5;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_W         = 5;
  localparam int NUM_CH        = 4;
  localparam int CLAMP_MAX     = 255;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y     = 2'd2;

  // Color model codes
  localparam logic CM_RGBA = 1'b0;
  localparam logic CM_LUM  = 1'b1;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 5'd2;

  typedef enum logic {
    ST_IDLE,
    ST_DIVIDE
  } bfd_state_t;

  typedef struct packed {
    logic [NUM_CH-1:0][PIX_W-1:0] chan;
    logic                         present;
    logic [COORD_W-1:0]           wx;
    logic [COORD_W-1:0]           wy;
  } bfd_pixel_t;

  typedef struct packed {
    logic [NUM_CH-1:0][PIX_W-1:0] avg;
    logic                         any_present;
    logic [PCNT_W-1:0]            present_count;
    logic [COORD_W-1:0]           ox;
    logic [COORD_W-1:0]           oy;
  } bfd_result_t;

  typedef struct packed {
    logic accept;
    logic load;
    logic step;
    logic publish;
  } bfd_cmd_t;

  typedef struct packed {
    logic win_end;
    logic div_done;
    logic out_free;
  } bfd_sts_t;

endpackage

// ===== rtl/bfd_if.sv =====
// Pixel and result channel interfaces of the box filter downscaler.
`timescale 1ns / 1ps

interface bfd_in_if;
  import bfd_pkg::*;
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   chan_a;
  logic [PIX_W-1:0]   chan_b;
  logic [PIX_W-1:0]   chan_c;
  logic [PIX_W-1:0]   chan_d;
  logic               pixel_present;
  logic [COORD_W-1:0] window_x;
  logic [COORD_W-1:0] window_y;

  modport source (output valid, chan_a, chan_b, chan_c, chan_d, pixel_present,
                  window_x, window_y, input ready);
  modport sink (input valid, chan_a, chan_b, chan_c, chan_d, pixel_present,
                window_x, window_y, output ready);
endinterface

interface bfd_out_if;
  import bfd_pkg::*;
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   avg_a;
  logic [PIX_W-1:0]   avg_b;
  logic [PIX_W-1:0]   avg_c;
  logic [PIX_W-1:0]   avg_d;
  logic               any_present;
  logic [PCNT_W-1:0]  present_count;
  logic [COORD_W-1:0] out_x;
  logic [COORD_W-1:0] out_y;

  modport source (output valid, avg_a, avg_b, avg_c, avg_d, any_present,
                  present_count, out_x, out_y, input ready);
  modport sink (input valid, avg_a, avg_b, avg_c, avg_d, any_present,
                present_count, out_x, out_y, output ready);
endinterface

// ===== rtl/bfd_ctrl.sv =====
// Controller state machine: input handshake and divider sequencing.
`timescale 1ns / 1ps

module bfd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  bfd_pkg::bfd_sts_t sts,
  output logic              in_ready,
  output bfd_pkg::bfd_cmd_t cmd
);
  import bfd_pkg::*;

  bfd_state_t state_r;
  bfd_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && sts.win_end) state_nxt = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (sts.div_done && sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    // a window's last item waits until the divider is free
    in_ready    = !sts.win_end || (state_r == ST_IDLE);
    cmd.accept  = in_valid && in_ready;
    cmd.load    = cmd.accept && sts.win_end;
    cmd.step    = (state_r == ST_DIVIDE) && !sts.div_done;
    cmd.publish = (state_r == ST_DIVIDE) && sts.div_done && sts.out_free;
  end

endmodule

// ===== rtl/bfd_datapath.sv =====
// Datapath: config registers, window accumulators, four-lane divider, output register.
`timescale 1ns / 1ps

module bfd_datapath #(
  parameter int MAX_SCALE = bfd_pkg::MAX_SCALE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bfd_pkg::CFG_W-1:0]      cfg_wdata,
  input  bfd_pkg::bfd_pixel_t            pix,
  input  bfd_pkg::bfd_cmd_t              cmd,
  output bfd_pkg::bfd_sts_t              sts,
  input  logic                           out_ready,
  output logic                           out_valid,
  output bfd_pkg::bfd_result_t           res
);
  import bfd_pkg::*;

  localparam int EFF_W  = $clog2(MAX_SCALE + 1);
  localparam int TOT_W  = 2 * EFF_W;
  localparam int CNT_W  = $clog2(MAX_SCALE * MAX_SCALE + 1);
  localparam int IDX_W  = (MAX_SCALE > 1) ? $clog2(MAX_SCALE * MAX_SCALE) : 1;
  localparam int SUM_W  = $clog2(MAX_SCALE * MAX_SCALE * CLAMP_MAX + 1);
  localparam int STEP_W = $clog2(SUM_W + 1);

  logic               color_r;
  logic [SCALE_W-1:0] scale_x_r;
  logic [SCALE_W-1:0] scale_y_r;

  logic [EFF_W-1:0] sx_eff;
  logic [EFF_W-1:0] sy_eff;
  logic [TOT_W-1:0] total;
  logic             win_end;

  logic [NUM_CH-1:0][SUM_W-1:0] sum_r;
  logic [NUM_CH-1:0][SUM_W-1:0] sum_add;
  logic [CNT_W-1:0]             cnt_r;
  logic [CNT_W-1:0]             cnt_add;
  logic [IDX_W-1:0]             idx_r;

  logic [NUM_CH-1:0][SUM_W-1:0] quo_r;
  logic [NUM_CH-1:0][SUM_W-1:0] quo_nxt;
  logic [NUM_CH-1:0][CNT_W-1:0] rem_r;
  logic [NUM_CH-1:0][CNT_W-1:0] rem_nxt;
  logic [CNT_W-1:0]             div_r;
  logic [STEP_W-1:0]            step_r;
  logic                         mode_r;
  logic [COORD_W-1:0]           ox_r;
  logic [COORD_W-1:0]           oy_r;

  logic                         out_valid_r;
  bfd_result_t                  res_r;
  bfd_result_t                  res_nxt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r   <= CM_RGBA;
      scale_x_r <= SCALE_RESET;
      scale_y_r <= SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLOR_MODEL: color_r   <= cfg_wdata[0];
        CFG_SCALE_X:     scale_x_r <= cfg_wdata[SCALE_W-1:0];
        CFG_SCALE_Y:     scale_y_r <= cfg_wdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, anything above the maximum acts as the maximum
  always_comb begin
    if (scale_x_r == '0) sx_eff = EFF_W'(1);
    else if (32'(scale_x_r) > 32'(MAX_SCALE)) sx_eff = EFF_W'(MAX_SCALE);
    else sx_eff = EFF_W'(scale_x_r);
    if (scale_y_r == '0) sy_eff = EFF_W'(1);
    else if (32'(scale_y_r) > 32'(MAX_SCALE)) sy_eff = EFF_W'(MAX_SCALE);
    else sy_eff = EFF_W'(scale_y_r);
    total   = TOT_W'(sx_eff) * TOT_W'(sy_eff);
    win_end = (32'(idx_r) + 32'd1) >= 32'(total);
  end

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      sum_add[i] = sum_r[i] + (pix.present ? SUM_W'(pix.chan[i]) : SUM_W'(0));
    end
    cnt_add = cnt_r + CNT_W'(pix.present);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
      idx_r <= '0;
    end else if (cmd.accept) begin
      if (win_end) begin
        sum_r <= '0;
        cnt_r <= '0;
        idx_r <= '0;
      end else begin
        sum_r <= sum_add;
        cnt_r <= cnt_add;
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  // one restoring quotient bit per lane and cycle
  always_comb begin
    logic [CNT_W:0]   rem_sh;
    logic [CNT_W+1:0] diff;
    rem_sh = '0;
    diff   = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      rem_sh = {rem_r[i], quo_r[i][SUM_W-1]};
      diff   = {1'b0, rem_sh} - {2'b00, div_r};
      if (!diff[CNT_W+1]) begin
        rem_nxt[i] = diff[CNT_W-1:0];
        quo_nxt[i] = {quo_r[i][SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt[i] = rem_sh[CNT_W-1:0];
        quo_nxt[i] = {quo_r[i][SUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (cmd.load) begin
      step_r <= '0;
    end else if (cmd.step) begin
      step_r <= step_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo_r  <= sum_add;
      rem_r  <= '0;
      div_r  <= cnt_add;
      mode_r <= color_r;
      ox_r   <= pix.wx;
      oy_r   <= pix.wy;
    end else if (cmd.step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_comb begin
    res_nxt.any_present   = (div_r != '0);
    res_nxt.present_count = PCNT_W'(div_r);
    res_nxt.ox            = ox_r;
    res_nxt.oy            = oy_r;
    for (int i = 0; i < NUM_CH; i++) begin
      if ((div_r == '0) || ((mode_r == CM_LUM) && (i >= 2))) begin
        res_nxt.avg[i] = '0;
      end else if (quo_r[i] > SUM_W'(CLAMP_MAX)) begin
        res_nxt.avg[i] = PIX_W'(CLAMP_MAX);
      end else begin
        res_nxt.avg[i] = PIX_W'(quo_r[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) res_r <= res_nxt;
  end

  assign sts.win_end  = win_end;
  assign sts.div_done = (step_r == STEP_W'(SUM_W));
  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign res          = res_r;

endmodule

// ===== rtl/box_filter_downscale_core.sv =====
// Pixels are taken one per cycle; a window's last pixel is taken only while the divider is idle.
// The divider produces one quotient bit per cycle; the quotient is as wide as the sum, 16 bits
// at the default maximum scale. A window's last pixel loads the divider, which then steps
// through the quotient bits and publishes the result once the output register is free.
// Reset (rst_n low, synchronous) empties the accumulators, clears the output valid flag and sets
// color model RGBA and a 2 by 2 window.
`timescale 1ns / 1ps

module box_filter_downscale_core #(
  parameter int MAX_SCALE = bfd_pkg::MAX_SCALE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bfd_in_if.sink                        in_chan,
  bfd_out_if.source                     out_res,
  input  logic                          cfg_we,
  input  logic [bfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bfd_pkg::CFG_W-1:0]     cfg_wdata
);
  import bfd_pkg::*;

  bfd_pixel_t  pix;
  bfd_result_t res;
  bfd_cmd_t    cmd;
  bfd_sts_t    sts;
  logic        in_ready;
  logic        out_valid;

  assign pix.chan[0] = in_chan.chan_a;
  assign pix.chan[1] = in_chan.chan_b;
  assign pix.chan[2] = in_chan.chan_c;
  assign pix.chan[3] = in_chan.chan_d;
  assign pix.present = in_chan.pixel_present;
  assign pix.wx      = in_chan.window_x;
  assign pix.wy      = in_chan.window_y;
  assign in_chan.ready = in_ready;

  bfd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  bfd_datapath #(
    .MAX_SCALE (MAX_SCALE)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pix       (pix),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_res.ready),
    .out_valid (out_valid),
    .res       (res)
  );

  assign out_res.valid         = out_valid;
  assign out_res.avg_a         = res.avg[0];
  assign out_res.avg_b         = res.avg[1];
  assign out_res.avg_c         = res.avg[2];
  assign out_res.avg_d         = res.avg[3];
  assign out_res.any_present   = res.any_present;
  assign out_res.present_count = res.present_count;
  assign out_res.out_x         = res.ox;
  assign out_res.out_y         = res.oy;

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the box filter downscaler: random pixel streams vs. a predictor.
`timescale 1ns / 1ps

module tb;
  import bfd_pkg::*;

  localparam int RESET_CYCLES  = 5;
  localparam int SETTLE_CYCLES = 30;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ITEMS  = 300;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int WIDE_WINDOW   = 32;

  // Index with no register behind it; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum int {
    PRES_ALL,
    PRES_MIXED,
    PRES_SPARSE,
    PRES_NONE
  } presence_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  bfd_in_if  in_bus ();
  bfd_out_if out_bus ();

  box_filter_downscale_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_res  (out_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Register copies and window accumulators of the predictor
  logic               cur_color;
  logic [SCALE_W-1:0] cur_sx;
  logic [SCALE_W-1:0] cur_sy;
  logic [15:0]        win_sum [NUM_CH];
  logic [PCNT_W-1:0]  win_count;
  int unsigned        win_pixels;

  bfd_pixel_t  pixel_queue [$];
  bfd_result_t window_queue [$];
  bfd_pixel_t  tx_item;

  int unsigned pixels_queued;
  int unsigned pixels_taken;
  int unsigned windows_expected;
  int unsigned windows_checked;
  int unsigned reg_writes;
  int unsigned err_count;
  int unsigned cycle_count;
  int          tx_gap;
  int          tx_gap_max;
  int          rx_wait;
  int          rx_stall_max;
  logic        hold_request;

  function automatic int eff_scale(logic [SCALE_W-1:0] s);
    if (s == 0) return 1;
    if (s > MAX_SCALE_DEF) return MAX_SCALE_DEF;
    return int'(s);
  endfunction

  function automatic logic [PIX_W-1:0] pick_level();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic logic [SCALE_W-1:0] draw_scale();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return SCALE_W'($urandom_range(MAX_SCALE_DEF + 1, 31));
      2: return SCALE_W'(MAX_SCALE_DEF);
      default: return SCALE_W'($urandom_range(1, 4));
    endcase
  endfunction

  task automatic note_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      note_error($sformatf("window %0d %s = %0h, want %0h", windows_checked, name, got, want));
  endtask

  // Accumulate one accepted pixel; close the window once its pixel count reaches the size.
  task automatic absorb_pixel(bfd_pixel_t px);
    bfd_result_t res;
    int unsigned q;
    int          i;
    if (px.present) begin
      for (i = 0; i < NUM_CH; i++) win_sum[i] = win_sum[i] + 16'(px.chan[i]);
      win_count = win_count + PCNT_W'(1);
    end
    pixels_taken++;
    win_pixels++;
    if (win_pixels >= eff_scale(cur_sx) * eff_scale(cur_sy)) begin
      for (i = 0; i < NUM_CH; i++) begin
        q = (win_count == 0) ? 0 : 32'(win_sum[i]) / 32'(win_count);
        if (q > CLAMP_MAX) q = CLAMP_MAX;
        if (cur_color == CM_LUM && i >= 2) q = 0;
        res.avg[i] = q[PIX_W-1:0];
      end
      res.any_present   = (win_count != 0);
      res.present_count = win_count;
      res.ox            = px.wx;
      res.oy            = px.wy;
      window_queue.push_back(res);
      windows_expected++;
      for (i = 0; i < NUM_CH; i++) win_sum[i] = '0;
      win_count  = '0;
      win_pixels = 0;
    end
  endtask

  task automatic check_window();
    bfd_result_t want;
    if (window_queue.size() == 0) begin
      note_error("result offered with no window pending");
    end else begin
      want = window_queue.pop_front();
      check_field("avg_a", 32'(out_bus.avg_a), 32'(want.avg[0]));
      check_field("avg_b", 32'(out_bus.avg_b), 32'(want.avg[1]));
      check_field("avg_c", 32'(out_bus.avg_c), 32'(want.avg[2]));
      check_field("avg_d", 32'(out_bus.avg_d), 32'(want.avg[3]));
      check_field("any_present", 32'(out_bus.any_present), 32'(want.any_present));
      check_field("present_count", 32'(out_bus.present_count), 32'(want.present_count));
      check_field("out_x", 32'(out_bus.out_x), 32'(want.ox));
      check_field("out_y", 32'(out_bus.out_y), 32'(want.oy));
    end
    windows_checked++;
  endtask

  // Pixel driver: hold the item until taken, then wait the drawn gap before the next.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) absorb_pixel(tx_item);
      if (!in_bus.valid || in_bus.ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_bus.valid <= 1'b0;
        end else if (pixel_queue.size() > 0) begin
          tx_item = pixel_queue.pop_front();
          in_bus.chan_a        <= tx_item.chan[0];
          in_bus.chan_b        <= tx_item.chan[1];
          in_bus.chan_c        <= tx_item.chan[2];
          in_bus.chan_d        <= tx_item.chan[3];
          in_bus.pixel_present <= tx_item.present;
          in_bus.window_x      <= tx_item.wx;
          in_bus.window_y      <= tx_item.wy;
          in_bus.valid         <= 1'b1;
          tx_gap = $urandom_range(0, tx_gap_max);
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each taken result, then stall for the drawn count.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        check_window();
        rx_wait = $urandom_range(0, rx_stall_max);
      end
      if (hold_request) begin
        rx_wait      = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d windows outstanding", cycle_count,
               windows_expected - windows_checked);
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_COLOR_MODEL: cur_color = val[0];
      CFG_SCALE_X:     cur_sx    = val;
      CFG_SCALE_Y:     cur_sy    = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic push_pixel(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b, logic [PIX_W-1:0] c,
                            logic [PIX_W-1:0] d, logic p, logic [COORD_W-1:0] x,
                            logic [COORD_W-1:0] y);
    bfd_pixel_t px;
    px.chan[0] = a;
    px.chan[1] = b;
    px.chan[2] = c;
    px.chan[3] = d;
    px.present = p;
    px.wx      = x;
    px.wy      = y;
    pixel_queue.push_back(px);
    pixels_queued++;
  endtask

  // Drain everything: all queued pixels taken and all expected windows checked, then idle.
  task automatic settle();
    wait (pixels_taken == pixels_queued);
    wait (windows_checked == windows_expected);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(int tx_max, int rx_max);
    @(negedge clk);
    tx_gap_max   = tx_max;
    rx_stall_max = rx_max;
  endtask

  // Stream n pixels; pixels of one window share its origin, a few carry stray coordinates.
  task automatic run_phase(int n, presence_t mode);
    int                 total;
    int                 k;
    logic [COORD_W-1:0] bx;
    logic [COORD_W-1:0] by;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               p;
    total = eff_scale(cur_sx) * eff_scale(cur_sy);
    bx    = COORD_W'($urandom);
    by    = COORD_W'($urandom);
    @(negedge clk);
    for (k = 0; k < n; k++) begin
      x = bx + COORD_W'((k / total) * eff_scale(cur_sx));
      y = by + COORD_W'(((k / total) / 8) * eff_scale(cur_sy));
      if ($urandom_range(0, 9) == 0) begin
        x = COORD_W'($urandom);
        y = COORD_W'($urandom);
      end
      case (mode)
        PRES_ALL:    p = 1'b1;
        PRES_MIXED:  p = 1'($urandom_range(0, 1));
        PRES_SPARSE: p = ($urandom_range(0, 7) == 0);
        default:     p = 1'b0;
      endcase
      push_pixel(pick_level(), pick_level(), pick_level(), pick_level(), p, x, y);
    end
    settle();
  endtask

  initial begin
    logic [SCALE_W-1:0] sx;
    logic [SCALE_W-1:0] sy;
    int unsigned        random_items;
    int                 phase;
    int                 k;

    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_wdata            = '0;
    in_bus.valid         = 1'b0;
    in_bus.chan_a        = '0;
    in_bus.chan_b        = '0;
    in_bus.chan_c        = '0;
    in_bus.chan_d        = '0;
    in_bus.pixel_present = 1'b0;
    in_bus.window_x      = '0;
    in_bus.window_y      = '0;
    out_bus.ready        = 1'b0;
    hold_request         = 1'b0;
    tx_gap_max           = 3;
    rx_stall_max         = 3;
    cur_color            = CM_RGBA;
    cur_sx               = SCALE_RESET;
    cur_sy               = SCALE_RESET;
    for (k = 0; k < NUM_CH; k++) win_sum[k] = '0;
    win_count            = '0;
    win_pixels           = 0;
    pixels_queued        = 0;
    pixels_taken         = 0;
    windows_expected     = 0;
    windows_checked      = 0;
    reg_writes           = 0;
    err_count            = 0;
    cycle_count          = 0;
    random_items         = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: 2 by 2 RGBA. Full white, an empty window, then a mixed one.
    @(negedge clk);
    for (k = 0; k < 4; k++) push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 16'h0000, 16'h0000);
    for (k = 0; k < 4; k++) push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 16'hFFFF, 16'hFFFF);
    push_pixel(8'd10, 8'd200, 8'd0, 8'd255, 1'b1, 16'hA5A5, 16'h5A5A);
    push_pixel(8'd11, 8'd100, 8'd0, 8'd255, 1'b0, 16'hA5A5, 16'h5A5A);
    push_pixel(8'd11, 8'd7, 8'd3, 8'd0, 1'b1, 16'hA5A5, 16'h5A5A);
    push_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 16'hA5A5, 16'h5A5A);
    settle();

    // Luminance, one pixel per window: c and d are summed but reported as zero.
    write_reg(CFG_COLOR_MODEL, CFG_W'(CM_LUM));
    write_reg(CFG_SCALE_X, 5'd1);
    write_reg(CFG_SCALE_Y, 5'd1);
    @(negedge clk);
    push_pixel(8'd200, 8'd100, 8'd50, 8'd25, 1'b1, 16'd1, 16'd2);
    push_pixel(8'd9, 8'd8, 8'd7, 8'd6, 1'b0, 16'd3, 16'd4);
    settle();

    // Zero scale acts as one; shrink the window and change mode with two pixels in.
    write_reg(CFG_SCALE_X, 5'd0);
    write_reg(CFG_SCALE_Y, 5'd3);
    @(negedge clk);
    push_pixel(8'd100, 8'd50, 8'd250, 8'd250, 1'b1, 16'd7, 16'd9);
    push_pixel(8'd100, 8'd50, 8'd250, 8'd250, 1'b1, 16'd7, 16'd9);
    settle();
    write_reg(CFG_COLOR_MODEL, CFG_W'(CM_RGBA));
    write_reg(CFG_SCALE_Y, 5'd1);
    write_reg(CFG_SPARE, 5'h1F);
    @(negedge clk);
    push_pixel(8'd101, 8'd51, 8'd251, 8'd251, 1'b1, 16'd8, 16'd10);
    settle();

    // Largest window, all present at full scale: count 256, sums at their top.
    write_reg(CFG_SCALE_X, SCALE_W'(MAX_SCALE_DEF));
    write_reg(CFG_SCALE_Y, SCALE_W'(MAX_SCALE_DEF));
    set_idling(0, 0);
    @(negedge clk);
    for (k = 0; k < MAX_SCALE_DEF * MAX_SCALE_DEF; k++)
      push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF);
    settle();

    // Oversized scale register clamps to the maximum.
    write_reg(CFG_SCALE_X, 5'd31);
    write_reg(CFG_SCALE_Y, 5'd1);
    set_idling(2, 2);
    run_phase(WIDE_WINDOW, PRES_MIXED);

    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      phase++;
      sx = draw_scale();
      sy = draw_scale();
      if (eff_scale(sx) * eff_scale(sy) > WIDE_WINDOW) sy = SCALE_W'($urandom_range(0, 1));
      if ($urandom_range(0, 1)) write_reg(CFG_COLOR_MODEL, CFG_W'($urandom));
      write_reg(CFG_SCALE_X, sx);
      write_reg(CFG_SCALE_Y, sy);
      if (phase == 3) begin
        // Hold the output off while pixels keep coming, so the block backs up.
        write_reg(CFG_SCALE_X, 5'd2);
        write_reg(CFG_SCALE_Y, 5'd1);
        set_idling(0, 0);
        hold_request = 1'b1;
        k = 80;
        run_phase(k, PRES_MIXED);
      end else begin
        case ($urandom_range(0, 2))
          0: set_idling(0, 0);
          1: set_idling(4, 19);
          default: set_idling(19, 4);
        endcase
        k = $urandom_range(8, 60);
        run_phase(k, presence_t'($urandom_range(0, 3)));
      end
      random_items += k;
    end

    settle();
    $display("Checked %0d windows from %0d pixels over %0d register writes,",
             windows_checked, pixels_taken, reg_writes);
    $display("with empty, luminance, clamped-scale, mid-window and backed-up output cases.");
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== box_filter_downscale_core.f =====
rtl/bfd_pkg.sv
rtl/bfd_if.sv
rtl/bfd_ctrl.sv
rtl/bfd_datapath.sv
rtl/box_filter_downscale_core.sv
test/tb.sv
